@@ src/hashed_lru_key_cache_defines.svh @@
// assertion macros for the key cache
`ifndef HASHED_LRU_KEY_CACHE_DEFINES_SVH
`define HASHED_LRU_KEY_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define HLKC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("hlkc check failed");
`define HLKC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("hlkc check failed");
`else
`define HLKC_ASSERT(lbl, prop)
`define HLKC_ASSERT_RST(lbl, prop)
`endif
`endif

@@ src/hlkc_pkg.sv @@
package hlkc_pkg;

  localparam int WORD_W      = 16;
  localparam int KEY_WORDS   = 10;
  localparam int KEY_W       = WORD_W * KEY_WORDS;
  localparam int BUCKETS     = 16384;
  localparam int BUCKET_W    = 14;
  localparam logic [BUCKET_W-1:0] BUCKET_MASK = 14'h2FFF;
  localparam int HASH_W      = 32;
  localparam int HASH_STEPS  = 8;
  localparam int ENTRY_ID_W  = 15;
  localparam int EVICT_W     = 4;
  localparam int USED_W      = 16;
  localparam int TARGET_W    = 15;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd25000;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic {
    REG_KEEP_ALL     = 1'b0,
    REG_TARGET_USAGE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
    logic [WORD_W-1:0] key_word_4;
    logic [WORD_W-1:0] key_word_5;
    logic [WORD_W-1:0] key_word_6;
    logic [WORD_W-1:0] key_word_7;
    logic [WORD_W-1:0] key_word_8;
    logic [WORD_W-1:0] key_word_9;
  } in_t;

  typedef struct packed {
    logic [ENTRY_ID_W-1:0] entry_id;
    logic                  hit;
    logic                  no_room;
    logic [EVICT_W-1:0]    evicted_count;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_L_HEAD, S_L_FIRST, S_L_READ, S_L_CMP,
    S_M1, S_M2, S_M3, S_I_A, S_I_B, S_I_C, S_E_TEST, S_E_B, S_E_C, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_HASH, OP_L_FIRST, OP_L_READ, OP_L_CMP,
    OP_M1, OP_M2, OP_M3, OP_I_A, OP_I_B, OP_I_C, OP_E_TEST, OP_E_B, OP_E_C,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic is_insert;
    logic free_empty;
    logic keep_all;
    logic head_zero;
    logic key_match;
    logic mid_list;
    logic chain_end;
    logic evict_more;
    logic oldest_zero;
    logic out_stall;
  } status_t;

  function automatic logic [4:0] hash_shift(input logic [2:0] idx);
    logic [4:0] s;
    unique case (idx)
      3'd0: s = 5'd4;
      3'd1: s = 5'd7;
      3'd2: s = 5'd10;
      3'd3: s = 5'd13;
      3'd4: s = 5'd15;
      3'd5: s = 5'd15;
      3'd6: s = 5'd15;
      3'd7: s = 5'd1;
      default: s = 5'd1;
    endcase
    return s;
  endfunction

endpackage

@@ src/hlkc_ctrl.sv @@
module hlkc_ctrl
  import hlkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (status.clear_last) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_HASH;
      S_HASH: begin
        if (status.hash_last) begin
          if (!status.is_insert) state_next = S_L_HEAD;
          else if (status.free_empty) state_next = S_DONE;
          else state_next = S_I_A;
        end
      end
      S_L_HEAD:  state_next = S_L_FIRST;
      S_L_FIRST: state_next = status.head_zero ? S_DONE : S_L_READ;
      S_L_READ:  state_next = S_L_CMP;
      S_L_CMP: begin
        if (status.key_match) state_next = status.mid_list ? S_M1 : S_DONE;
        else state_next = status.chain_end ? S_DONE : S_L_READ;
      end
      S_M1:      state_next = S_M2;
      S_M2:      state_next = S_M3;
      S_M3:      state_next = S_DONE;
      S_I_A:     state_next = S_I_B;
      S_I_B:     state_next = S_I_C;
      S_I_C:     state_next = status.keep_all ? S_DONE : S_E_TEST;
      S_E_TEST: begin
        if (!status.evict_more) state_next = S_DONE;
        else if (!status.oldest_zero) state_next = S_E_B;
      end
      S_E_B:     state_next = S_E_C;
      S_E_C:     state_next = S_E_TEST;
      S_DONE:    if (!status.out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, in_ready: 1'b0};
    unique case (state)
      S_CLEAR:   cmd.op = OP_CLEAR;
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_HASH:    cmd.op = OP_HASH;
      S_L_HEAD:  cmd.op = OP_NONE;
      S_L_FIRST: cmd.op = OP_L_FIRST;
      S_L_READ:  cmd.op = OP_L_READ;
      S_L_CMP:   cmd.op = OP_L_CMP;
      S_M1:      cmd.op = OP_M1;
      S_M2:      cmd.op = OP_M2;
      S_M3:      cmd.op = OP_M3;
      S_I_A:     cmd.op = OP_I_A;
      S_I_B:     cmd.op = OP_I_B;
      S_I_C:     cmd.op = OP_I_C;
      S_E_TEST:  cmd.op = OP_E_TEST;
      S_E_B:     cmd.op = OP_E_B;
      S_E_C:     cmd.op = OP_E_C;
      S_DONE:    cmd.op = OP_DONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ src/hlkc_datapath.sv @@
module hlkc_datapath
  import hlkc_pkg::*;
#(
  parameter int ENTRY_SLOTS = 32768,
  parameter int MAX_EVICT   = 10,
  localparam int ID_W       = $clog2(ENTRY_SLOTS),
  localparam int ROUND_W    = $clog2(MAX_EVICT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  in_t                 in_data,
  input  logic                keep_all,
  input  logic [TARGET_W-1:0] target_usage,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data
);

  // memories
  logic [ID_W-1:0]     bh_mem [BUCKETS];
  logic [KEY_W-1:0]    key_mem [ENTRY_SLOTS];
  logic [BUCKET_W-1:0] eb_mem [ENTRY_SLOTS];
  logic [ID_W-1:0]     ap_mem [ENTRY_SLOTS];
  logic [ID_W-1:0]     an_mem [ENTRY_SLOTS];
  logic [ID_W-1:0]     cp_mem [ENTRY_SLOTS];
  logic [ID_W-1:0]     cn_mem [ENTRY_SLOTS];

  in_t                 key_r;
  logic                is_ins;
  logic [HASH_W-1:0]   r;
  logic [2:0]          hidx;
  logic [BUCKET_W-1:0] clr;
  logic [ID_W-1:0]     cur, p, n, head, fh, oldest, newest, steps;
  logic [ID_W:0]       mark;
  logic [USED_W-1:0]   used;
  logic [ROUND_W-1:0]  round;
  out_t                res;

  // registered read data
  logic [ID_W-1:0]     ra_q, ap_q, an_q, cp_q, cn_q, hd_q;
  logic                unt_q;
  logic [KEY_W-1:0]    key_q;
  logic [BUCKET_W-1:0] eb_q;

  logic [WORD_W-1:0]   kw [KEY_WORDS];
  logic [KEY_W-1:0]    key_vec;
  logic [BUCKET_W-1:0] bucket;
  logic [ID_W-1:0]     ap_e, an_e, cp_e, cn_e, link_ra;
  logic [3:0]          widx;

  logic                ap_we, an_we, cp_we, cn_we, bh_we, pool_we;
  logic [ID_W-1:0]     ap_wa, an_wa, cp_wa, cn_wa;
  logic [ID_W-1:0]     ap_wd, an_wd, cp_wd, cn_wd, bh_wd;
  logic [BUCKET_W-1:0] bh_wa;

  assign kw[0] = key_r.key_word_0;
  assign kw[1] = key_r.key_word_1;
  assign kw[2] = key_r.key_word_2;
  assign kw[3] = key_r.key_word_3;
  assign kw[4] = key_r.key_word_4;
  assign kw[5] = key_r.key_word_5;
  assign kw[6] = key_r.key_word_6;
  assign kw[7] = key_r.key_word_7;
  assign kw[8] = key_r.key_word_8;
  assign kw[9] = key_r.key_word_9;

  assign key_vec = {kw[9], kw[8], kw[7], kw[6], kw[5], kw[4], kw[3], kw[2], kw[1], kw[0]};
  assign bucket  = r[BUCKET_W-1:0] & BUCKET_MASK;
  assign widx    = {1'b0, hidx} + 4'd2;

  // entries below the mark were never allocated; they read as zero links, ap as the slot below
  assign ap_e = unt_q ? ra_q - 1'b1 : ap_q;
  assign an_e = unt_q ? '0 : an_q;
  assign cp_e = unt_q ? '0 : cp_q;
  assign cn_e = unt_q ? '0 : cn_q;

  always_comb begin
    unique case (cmd.op)
      OP_I_A:    link_ra = fh;
      OP_E_TEST: link_ra = oldest;
      default:   link_ra = cur;
    endcase
  end

  always_comb begin
    ap_we = 1'b0; ap_wa = cur; ap_wd = '0;
    an_we = 1'b0; an_wa = cur; an_wd = '0;
    cp_we = 1'b0; cp_wa = cur; cp_wd = '0;
    cn_we = 1'b0; cn_wa = cur; cn_wd = '0;
    bh_we = 1'b0; bh_wa = bucket; bh_wd = cur;
    pool_we = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        bh_we = 1'b1; bh_wa = clr; bh_wd = '0;
      end
      OP_M1: begin
        ap_we = 1'b1; ap_wa = n; ap_wd = p;
        an_we = 1'b1; an_wa = p; an_wd = n;
      end
      OP_M2: begin
        ap_we = 1'b1; ap_wd = newest;
        an_we = 1'b1; an_wa = newest; an_wd = cur;
      end
      OP_M3: begin
        an_we = 1'b1;
      end
      OP_I_B: begin
        ap_we = 1'b1; ap_wd = newest;
        an_we = (newest != '0); an_wa = newest; an_wd = cur;
        cp_we = 1'b1;
        pool_we = 1'b1;
      end
      OP_I_C: begin
        an_we = 1'b1;
        cp_we = (head != '0); cp_wa = head; cp_wd = cur;
        cn_we = 1'b1; cn_wd = head;
        bh_we = 1'b1;
      end
      OP_E_B: begin
        ap_we = (an_e != '0); ap_wa = an_e;
        cn_we = (cp_e != '0); cn_wa = cp_e; cn_wd = cn_e;
        cp_we = (cn_e != '0); cp_wa = cn_e; cp_wd = cp_e;
        bh_we = (cp_e == '0); bh_wa = eb_q; bh_wd = cn_e;
      end
      OP_E_C: begin
        ap_we = 1'b1; ap_wd = fh;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ap_we) ap_mem[ap_wa] <= ap_wd;
    if (an_we) an_mem[an_wa] <= an_wd;
    if (cp_we) cp_mem[cp_wa] <= cp_wd;
    if (cn_we) cn_mem[cn_wa] <= cn_wd;
    if (bh_we) bh_mem[bh_wa] <= bh_wd;
    if (pool_we) begin
      key_mem[cur] <= key_vec;
      eb_mem[cur]  <= bucket;
    end
    ap_q  <= ap_mem[link_ra];
    an_q  <= an_mem[link_ra];
    cp_q  <= cp_mem[link_ra];
    cn_q  <= cn_mem[link_ra];
    key_q <= key_mem[link_ra];
    eb_q  <= eb_mem[link_ra];
    hd_q  <= bh_mem[bucket];
    ra_q  <= link_ra;
    unt_q <= ({1'b0, link_ra} < mark);
  end

  assign status.clear_last  = (clr == '1);
  assign status.hash_last   = (hidx == 3'(HASH_STEPS - 1));
  assign status.is_insert   = is_ins;
  assign status.free_empty  = (fh == '0);
  assign status.keep_all    = keep_all;
  assign status.head_zero   = (hd_q == '0);
  assign status.key_match   = (key_q == key_vec);
  assign status.mid_list    = (ap_e != '0) && (an_e != '0);
  assign status.chain_end   = (cn_e == '0) || (steps == ID_W'(ENTRY_SLOTS - 1));
  assign status.evict_more  = (round != ROUND_W'(MAX_EVICT)) &&
                              (used > USED_W'(target_usage));
  assign status.oldest_zero = (oldest == '0);
  assign status.out_stall   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      fh        <= ID_W'(ENTRY_SLOTS - 1);
      mark      <= (ID_W + 1)'(ENTRY_SLOTS);
      oldest    <= '0;
      newest    <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_DONE && !status.out_stall) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr <= clr + 1'b1;
        OP_LOAD: begin
          key_r  <= in_data;
          is_ins <= in_data.opcode;
          r      <= (HASH_W'(in_data.key_word_0) << 1) + HASH_W'(in_data.key_word_1);
          hidx   <= '0;
          res    <= '{entry_id: '0, hit: 1'b0,
                      no_room: in_data.opcode && (fh == '0), evicted_count: '0};
        end
        OP_HASH: begin
          r    <= (r << hash_shift(hidx)) + HASH_W'(kw[widx]) +
                  ((hidx != '0) ? (r >> 16) : '0);
          hidx <= hidx + 1'b1;
        end
        OP_L_FIRST: begin
          cur   <= hd_q;
          steps <= '0;
        end
        OP_L_CMP: begin
          if (status.key_match) begin
            res.entry_id <= ENTRY_ID_W'(cur);
            res.hit      <= 1'b1;
            p            <= ap_e;
            n            <= an_e;
          end else begin
            cur   <= cn_e;
            steps <= steps + 1'b1;
          end
        end
        OP_M3: newest <= cur;
        OP_I_A: cur <= fh;
        OP_I_B: begin
          fh <= ap_e;
          if ({1'b0, cur} < mark) mark <= {1'b0, cur};
          if (newest == '0) oldest <= cur;
          newest       <= cur;
          used         <= used + 1'b1;
          head         <= hd_q;
          res.entry_id <= ENTRY_ID_W'(cur);
        end
        OP_I_C: round <= '0;
        OP_E_TEST: begin
          if (status.evict_more) begin
            round <= round + 1'b1;
            cur   <= oldest;
          end
        end
        OP_E_B: begin
          if (an_e != '0) begin
            oldest <= an_e;
          end else begin
            oldest <= '0;
            newest <= '0;
          end
        end
        OP_E_C: begin
          fh                <= cur;
          used              <= used - 1'b1;
          res.evicted_count <= res.evicted_count + 1'b1;
        end
        OP_DONE: begin
          if (!status.out_stall) begin
            out_data <= res;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/hashed_lru_key_cache.sv @@
// Keyed entry cache with hashed buckets and oldest-first eviction.
// Input channel (in_valid/in_ready/in_data) takes one lookup or insert per
// transfer; output channel (out_valid/out_ready/out_data) returns exactly one
// result per item, in order. The APB port sets keep_all and target_usage.
// Items are handled one at a time by a sequencer over memories with one read
// and one write port each: accept, HASH_STEPS rounds of iterative hashing, then
//   lookup: bucket read, a read and compare per chain entry, a move to the
//           newest end when a hit moves there, then the result out
//   insert: linking (skipped when no slot is free); unless keep_all is set,
//           eviction rounds (only a test when the recency list is empty) and
//           a closing check; then the result out
// After reset the bucket table is swept to zero, one bucket per cycle, through
// all 16384 buckets while in_ready stays low; configuration writes are taken.
// A finished result sits in the output register; the next item is accepted
// while it waits, and only the following result waits for out_ready.
module hashed_lru_key_cache
  import hlkc_pkg::*;
#(
  parameter int ENTRY_SLOTS = 32768,
  parameter int MAX_EVICT   = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

`include "hashed_lru_key_cache_defines.svh"

  logic                keep_all;
  logic [TARGET_W-1:0] target_usage;
  reg_idx_t            sel;
  cmd_t                cmd;
  status_t             status;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_all     <= 1'b0;
      target_usage <= TARGET_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_KEEP_ALL:     keep_all     <= pwdata[0];
        REG_TARGET_USAGE: target_usage <= pwdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_KEEP_ALL:     prdata = PDATA_W'(keep_all);
      REG_TARGET_USAGE: prdata = PDATA_W'(target_usage);
      default:          prdata = '0;
    endcase
  end

  hlkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  hlkc_datapath #(
    .ENTRY_SLOTS (ENTRY_SLOTS),
    .MAX_EVICT   (MAX_EVICT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (in_data),
    .keep_all     (keep_all),
    .target_usage (target_usage),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  assign in_ready = cmd.in_ready;

  `HLKC_ASSERT_RST(a_reset_blocks_input, $past(rst) |-> !in_ready)
  `HLKC_ASSERT(a_busy_after_transfer, in_valid && in_ready |=> !in_ready)
  `HLKC_ASSERT(a_flags_exclusive, out_valid |-> !(out_data.hit && out_data.no_room))
  `HLKC_ASSERT(a_no_room_zero_id, out_valid && out_data.no_room |-> out_data.entry_id == '0)
  `HLKC_ASSERT(a_evict_bound, out_valid |-> out_data.evicted_count <= EVICT_W'(MAX_EVICT))

endmodule
